// File: hdl/u8dw_pkg.sv
// Shared types and constants, including the column width ranges, for the UTF-8 width counter.
package u8dw_pkg;

  localparam int CP_BITS  = 21;
  localparam int OUT_BITS = 16;

  localparam logic [CP_BITS-1:0] CP_ZWSP     = 21'h0200B;
  localparam logic [CP_BITS-1:0] CP_COMB_LO  = 21'h00300;
  localparam logic [CP_BITS-1:0] CP_COMB_HI  = 21'h0036F;
  localparam logic [CP_BITS-1:0] CP_HANG_LO  = 21'h01100;
  localparam logic [CP_BITS-1:0] CP_HANG_HI  = 21'h0115F;
  localparam logic [CP_BITS-1:0] CP_CJK_LO   = 21'h02E80;
  localparam logic [CP_BITS-1:0] CP_CJK_HI   = 21'h0A4CF;
  localparam logic [CP_BITS-1:0] CP_HSYL_LO  = 21'h0AC00;
  localparam logic [CP_BITS-1:0] CP_HSYL_HI  = 21'h0D7A3;
  localparam logic [CP_BITS-1:0] CP_CMPT_LO  = 21'h0F900;
  localparam logic [CP_BITS-1:0] CP_CMPT_HI  = 21'h0FAFF;
  localparam logic [CP_BITS-1:0] CP_FULL_LO  = 21'h0FF00;
  localparam logic [CP_BITS-1:0] CP_FULL_HI  = 21'h0FF60;
  localparam logic [CP_BITS-1:0] CP_EMOJI_LO = 21'h1F300;
  localparam logic [CP_BITS-1:0] CP_EMOJI_HI = 21'h1FAFF;
  localparam logic [7:0]         CONT_MASK   = 8'h3F;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_string;
  } u8dw_in_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] total_columns;
    logic                saturated;
  } u8dw_out_t;

  typedef struct packed {
    logic [CP_BITS-1:0] pcp;
    logic [2:0]         expected;
    logic [2:0]         received;
  } u8dw_dec_t;

  typedef struct packed {
    logic               valid;
    logic [CP_BITS-1:0] cp;
  } u8dw_cp_t;

endpackage

// File: hdl/u8dw_width.sv
// Column width (0, 1 or 2) of one finished code point.
module u8dw_width import u8dw_pkg::*; (
  input  u8dw_cp_t   cp_i,
  output logic [1:0] width_o
);

  logic zero_w;
  logic wide_w;

  always_comb begin
    zero_w = (cp_i.cp == CP_ZWSP) || (cp_i.cp >= CP_COMB_LO && cp_i.cp <= CP_COMB_HI);
    wide_w = (cp_i.cp >= CP_HANG_LO  && cp_i.cp <= CP_HANG_HI)
          || (cp_i.cp >= CP_CJK_LO   && cp_i.cp <= CP_CJK_HI)
          || (cp_i.cp >= CP_HSYL_LO  && cp_i.cp <= CP_HSYL_HI)
          || (cp_i.cp >= CP_CMPT_LO  && cp_i.cp <= CP_CMPT_HI)
          || (cp_i.cp >= CP_FULL_LO  && cp_i.cp <= CP_FULL_HI)
          || (cp_i.cp >= CP_EMOJI_LO && cp_i.cp <= CP_EMOJI_HI);
    priority if (!cp_i.valid) begin
      width_o = 2'd0;
    end else if (zero_w) begin
      width_o = 2'd0;
    end else if (wide_w) begin
      width_o = 2'd2;
    end else begin
      width_o = 2'd1;
    end
  end

endmodule

// File: hdl/u8dw_decode.sv
// UTF-8 decode step: next sequence state and up to two finished code points per beat.
module u8dw_decode import u8dw_pkg::*; (
  input  u8dw_dec_t dec_i,
  input  u8dw_in_t  item_i,
  output u8dw_dec_t dec_o,
  output u8dw_cp_t  cp_a_o,
  output u8dw_cp_t  cp_b_o
);

  u8dw_dec_t          after_w;
  logic               pending_w;
  logic               cont_w;
  logic [CP_BITS-1:0] shifted_w;
  logic [2:0]         rcv_inc_w;
  u8dw_cp_t           byte_cp_w;

  always_comb begin
    pending_w = (dec_i.expected != LEN_NONE);
    cont_w    = (item_i.data_byte[7:6] == 2'b10);
    shifted_w = {dec_i.pcp[CP_BITS-7:0], item_i.data_byte[5:0] & CONT_MASK[5:0]};
    rcv_inc_w = dec_i.received + 3'd1;
    after_w   = dec_i;
    cp_a_o    = '0;
    byte_cp_w = '0;

    if (item_i.has_byte) begin
      if (pending_w && cont_w) begin
        if (rcv_inc_w >= dec_i.expected) begin
          cp_a_o  = '{valid: 1'b1, cp: shifted_w};
          after_w = '0;
        end else begin
          after_w = '{pcp: shifted_w, expected: dec_i.expected, received: rcv_inc_w};
        end
      end else begin
        if (pending_w) begin
          cp_a_o = '{valid: 1'b1, cp: dec_i.pcp};
        end
        after_w = '0;
        unique casez (item_i.data_byte)
          8'b0???????: byte_cp_w = '{valid: 1'b1, cp: CP_BITS'(item_i.data_byte)};
          8'b110?????: after_w = '{pcp: CP_BITS'(item_i.data_byte[4:0]),
                                   expected: LEN_TWO, received: 3'd1};
          8'b1110????: after_w = '{pcp: CP_BITS'(item_i.data_byte[3:0]),
                                   expected: LEN_THREE, received: 3'd1};
          8'b11110???: after_w = '{pcp: CP_BITS'(item_i.data_byte[2:0]),
                                   expected: LEN_FOUR, received: 3'd1};
          default:     after_w = '0;
        endcase
      end
    end

    // an ASCII byte leaves nothing pending, so the end flush never collides with it
    cp_b_o = byte_cp_w;
    if (item_i.end_of_string && after_w.expected != LEN_NONE) begin
      cp_b_o = '{valid: 1'b1, cp: after_w.pcp};
    end
    dec_o = item_i.end_of_string ? u8dw_dec_t'('0) : after_w;
  end

endmodule

// File: hdl/utf8_display_width_counter.sv
// Top level: input register, UTF-8 decode, saturating column counter, result register.
//
// Usage:
//   in_valid/in_ready/in_data carry one string byte per beat (has_byte=0 gives an
//   empty beat, end_of_string closes the string). out_valid/out_ready/out_data carry
//   one result per string: the column total, saturated at 2^COUNT_BITS-1 and shown
//   in 16 bits, plus a saturated flag.
//   Throughput: one beat per cycle while no end-of-string beat waits on a stalled result.
//   A byte is registered, then decoded and counted in the next cycle by a single pass
//   of decode and width compare logic feeding a three-input add and clamp; the total
//   of a string that ends is then held in the result register.
//   Stall: while a result waits in the output register, byte beats keep flowing; only
//   an end-of-string beat held in the input register waits, and then in_ready drops.
//   Reset: synchronous, active low; clears the decoder, the counter and both
//   valid flags. No clearing pass is needed, so in_ready is high right after reset.
module utf8_display_width_counter import u8dw_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  u8dw_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output u8dw_out_t out_data
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic                s1_valid_r;
  u8dw_in_t            s1_item_r;
  u8dw_dec_t           dec_r;
  u8dw_dec_t           dec_nxt;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [COUNT_BITS-1:0] cnt_nxt;
  logic                ovf_r;
  logic                ovf_nxt;
  logic                out_valid_r;
  u8dw_out_t           out_r;

  u8dw_cp_t            cp_a_w;
  u8dw_cp_t            cp_b_w;
  logic [1:0]          wid_a_w;
  logic [1:0]          wid_b_w;
  logic [COUNT_BITS:0] sum_w;
  logic                sat_w;
  logic                s1_go_w;
  logic                fire_w;

  u8dw_decode u_decode (
    .dec_i  (dec_r),
    .item_i (s1_item_r),
    .dec_o  (dec_nxt),
    .cp_a_o (cp_a_w),
    .cp_b_o (cp_b_w)
  );

  u8dw_width u_width_a (.cp_i(cp_a_w), .width_o(wid_a_w));
  u8dw_width u_width_b (.cp_i(cp_b_w), .width_o(wid_b_w));

  always_comb begin
    s1_go_w  = !s1_item_r.end_of_string || !out_valid_r || out_ready;
    fire_w   = s1_valid_r && s1_go_w;
    in_ready = !s1_valid_r || s1_go_w;
    sum_w    = {1'b0, cnt_r} + (COUNT_BITS+1)'(wid_a_w) + (COUNT_BITS+1)'(wid_b_w);
    sat_w    = (sum_w >= {1'b0, CNT_MAX});
    cnt_nxt  = sat_w ? CNT_MAX : sum_w[COUNT_BITS-1:0];
    ovf_nxt  = ovf_r | sat_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      dec_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (fire_w) begin
        dec_r <= dec_nxt;
        if (s1_item_r.end_of_string) begin
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          cnt_r <= cnt_nxt;
          ovf_r <= ovf_nxt;
        end
      end
      if (fire_w && s1_item_r.end_of_string) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
    if (fire_w && s1_item_r.end_of_string) begin
      out_r <= '{total_columns: OUT_BITS'(cnt_nxt), saturated: ovf_nxt};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hdl/u8dw_checker.sv
// Port-level assertions for the UTF-8 width counter, bound to the top level.
module u8dw_checker import u8dw_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input u8dw_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input u8dw_out_t out_data
);

  localparam logic [OUT_BITS-1:0] SAT_VAL = OUT_BITS'((64'd1 << COUNT_BITS) - 64'd1);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |-> out_data.total_columns == SAT_VAL)
    else $error("saturated flag without saturated total");

endmodule

bind utf8_display_width_counter u8dw_checker #(.COUNT_BITS(COUNT_BITS)) u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/tb_utf8_display_width_counter.sv
// Self-checking testbench for the UTF-8 display width counter.
`timescale 1ns / 1ps

module tb_utf8_display_width_counter import u8dw_pkg::*;;

  localparam int          CNT_BITS = 8;
  localparam longint unsigned CNT_MAX = (64'd1 << CNT_BITS) - 1;
  localparam int          RAND_BEATS = 1125;
  localparam int          DRAIN = 8;
  localparam int          LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  u8dw_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  u8dw_out_t out_data;

  u8dw_in_t  beat_q [$];
  u8dw_out_t totals_q [$];
  logic [CP_BITS-1:0] cp_marks [0:38];

  // decoder and counter state of the predictor
  logic [CP_BITS-1:0] pend_cp = '0;
  logic [2:0]         pend_len = LEN_NONE;
  logic [2:0]         pend_cnt = '0;
  longint unsigned    col_sum = 0;
  logic               sat_seen = 1'b0;

  bit failed = 1'b0;
  int in_beats = 0;
  int in_wait = 0;
  int gap_now = 0;
  bit in_burst = 1'b0;
  int n_out = 0;
  int out_wait = 0;
  int stall_now = 0;
  bit out_burst = 1'b0;
  int cycles = 0;
  u8dw_out_t want;

  utf8_display_width_counter #(.COUNT_BITS(CNT_BITS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  task automatic add_width(input logic [CP_BITS-1:0] cp);
    int unsigned w;
    if (cp == CP_ZWSP || (cp >= CP_COMB_LO && cp <= CP_COMB_HI)) begin
      w = 0;
    end else if ((cp >= CP_HANG_LO && cp <= CP_HANG_HI) ||
                 (cp >= CP_CJK_LO && cp <= CP_CJK_HI) ||
                 (cp >= CP_HSYL_LO && cp <= CP_HSYL_HI) ||
                 (cp >= CP_CMPT_LO && cp <= CP_CMPT_HI) ||
                 (cp >= CP_FULL_LO && cp <= CP_FULL_HI) ||
                 (cp >= CP_EMOJI_LO && cp <= CP_EMOJI_HI)) begin
      w = 2;
    end else begin
      w = 1;
    end
    col_sum = col_sum + w;
    if (col_sum >= CNT_MAX) begin
      col_sum  = CNT_MAX;
      sat_seen = 1'b1;
    end
  endtask

  task automatic flush_partial();
    if (pend_len != LEN_NONE) add_width(pend_cp);
    pend_cp  = '0;
    pend_len = LEN_NONE;
    pend_cnt = '0;
  endtask

  task automatic count_beat(input u8dw_in_t d);
    logic [7:0] b;
    u8dw_out_t  r;
    b = d.data_byte;
    if (d.has_byte) begin
      if (pend_len != LEN_NONE && b[7:6] == 2'b10) begin
        pend_cp  = (pend_cp << 6) | CP_BITS'(b & CONT_MASK);
        pend_cnt = pend_cnt + 3'd1;
        if (pend_cnt >= pend_len) flush_partial();
      end else begin
        flush_partial();
        if (!b[7]) begin
          add_width(CP_BITS'(b));
        end else if (b[7:5] == 3'b110) begin
          pend_cp  = CP_BITS'(b[4:0]);
          pend_len = LEN_TWO;
          pend_cnt = 3'd1;
        end else if (b[7:4] == 4'b1110) begin
          pend_cp  = CP_BITS'(b[3:0]);
          pend_len = LEN_THREE;
          pend_cnt = 3'd1;
        end else if (b[7:3] == 5'b11110) begin
          pend_cp  = CP_BITS'(b[2:0]);
          pend_len = LEN_FOUR;
          pend_cnt = 3'd1;
        end
      end
    end
    if (d.end_of_string) begin
      flush_partial();
      r.total_columns = col_sum[OUT_BITS-1:0];
      r.saturated     = sat_seen;
      totals_q.push_back(r);
      col_sum  = 0;
      sat_seen = 1'b0;
    end
  endtask

  task automatic put(input logic [7:0] b, input logic has, input logic eos);
    u8dw_in_t it;
    it.data_byte     = b;
    it.has_byte      = has;
    it.end_of_string = eos;
    beat_q.push_back(it);
  endtask

  task automatic put_cp(input logic [CP_BITS-1:0] cp, input bit truncate);
    logic [7:0] seq [4];
    int n;
    int cut;
    if (cp < 21'h80) begin
      seq[0] = cp[7:0];
      n = 1;
    end else if (cp < 21'h800) begin
      seq[0] = {3'b110, cp[10:6]};
      seq[1] = {2'b10, cp[5:0]};
      n = 2;
    end else if (cp < 21'h10000) begin
      seq[0] = {4'b1110, cp[15:12]};
      seq[1] = {2'b10, cp[11:6]};
      seq[2] = {2'b10, cp[5:0]};
      n = 3;
    end else begin
      seq[0] = {5'b11110, cp[20:18]};
      seq[1] = {2'b10, cp[17:12]};
      seq[2] = {2'b10, cp[11:6]};
      seq[3] = {2'b10, cp[5:0]};
      n = 4;
    end
    cut = (truncate && n > 1) ? $urandom_range(1, n - 1) : 0;
    for (int i = 0; i < n - cut; i++) put(seq[i], 1'b1, 1'b0);
  endtask

  function automatic logic [CP_BITS-1:0] pick_cp();
    logic [CP_BITS-1:0] cp;
    case ($urandom_range(0, 7))
      0, 1, 2: cp = CP_BITS'($urandom_range(0, 127));
      3:       cp = cp_marks[$urandom_range(0, 38)];
      4:       cp = CP_BITS'($urandom_range(32'h80, 32'h7FF));
      5:       cp = CP_BITS'($urandom_range(32'h800, 32'hFFFF));
      6:       cp = CP_BITS'($urandom_range(32'h10000, 32'h1FFFFF));
      default: cp = CP_BITS'($urandom_range(CP_CJK_LO, CP_CJK_HI));
    endcase
    return cp;
  endfunction

  task automatic make_string(input int n_cp);
    int start;
    u8dw_in_t last;
    start = beat_q.size();
    for (int k = 0; k < n_cp; k++) begin
      case ($urandom_range(0, 15))
        0:       put(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        1:       put(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        2:       put_cp(pick_cp(), 1'b1);
        default: put_cp(pick_cp(), 1'b0);
      endcase
    end
    if (beat_q.size() > start && $urandom_range(0, 1) == 1) begin
      last = beat_q.pop_back();
      last.end_of_string = 1'b1;
      beat_q.push_back(last);
    end else begin
      put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_wait  <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        count_beat(in_data);
        in_beats++;
        if (in_beats % 50 == 0) in_burst = ($urandom_range(0, 2) == 0);
        gap_now = in_burst ? 0 : $urandom_range(0, 14);
      end else begin
        gap_now = in_wait;
      end
      if (gap_now == 0 && beat_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= beat_q.pop_front();
      end else begin
        in_valid <= 1'b0;
        if (gap_now != 0) in_wait <= gap_now - 1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait  <= 0;
    end else if (out_valid && out_ready) begin
      if (totals_q.size() == 0) begin
        failed = 1'b1;
        $display("%0t: unexpected beat, expected none actual %0d/%0d", $time,
                 out_data.total_columns, out_data.saturated);
      end else begin
        want = totals_q.pop_front();
        if (out_data.total_columns !== want.total_columns) begin
          failed = 1'b1;
          $display("%0t: total_columns expected %0d actual %0d", $time,
                   want.total_columns, out_data.total_columns);
        end
        if (out_data.saturated !== want.saturated) begin
          failed = 1'b1;
          $display("%0t: saturated expected %0d actual %0d", $time,
                   want.saturated, out_data.saturated);
        end
      end
      n_out++;
      if (n_out % 16 == 0) out_burst = ($urandom_range(0, 2) == 0);
      stall_now = out_burst ? 0 : $urandom_range(0, 14);
      out_ready <= (stall_now == 0);
      out_wait  <= (stall_now == 0) ? 0 : stall_now - 1;
    end else if (!out_ready) begin
      if (out_wait == 0) out_ready <= 1'b1;
      else out_wait <= out_wait - 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    cp_marks = '{21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hFFFF, 21'h10000, 21'h1FFFFF,
                 21'h200A, 21'h200B, 21'h200C,
                 21'h2FF, 21'h300, 21'h36F, 21'h370,
                 21'h10FF, 21'h1100, 21'h115F, 21'h1160,
                 21'h2E7F, 21'h2E80, 21'hA4CF, 21'hA4D0,
                 21'hABFF, 21'hAC00, 21'hD7A3, 21'hD7A4,
                 21'hF8FF, 21'hF900, 21'hFAFF, 21'hFB00,
                 21'hFEFF, 21'hFF00, 21'hFF60, 21'hFF61,
                 21'h1F2FF, 21'h1F300, 21'h1FAFF, 21'h1FB00};

    // empty string, byte ignored
    put(8'hFF, 1'b0, 1'b1);
    // NUL and DEL
    put(8'h00, 1'b1, 1'b0);
    put(8'h7F, 1'b1, 1'b1);
    // stray continuations and invalid leads are skipped
    put(8'h80, 1'b1, 1'b0);
    put(8'hBF, 1'b1, 1'b0);
    put(8'hF8, 1'b1, 1'b0);
    put(8'hFF, 1'b1, 1'b0);
    put(8'h41, 1'b1, 1'b1);
    // zero width space, combining mark, emoji, end on an empty beat
    put(8'hE2, 1'b1, 1'b0);
    put(8'h80, 1'b1, 1'b0);
    put(8'h8B, 1'b1, 1'b0);
    put(8'hCC, 1'b1, 1'b0);
    put(8'h80, 1'b1, 1'b0);
    put(8'hF0, 1'b1, 1'b0);
    put(8'h9F, 1'b1, 1'b0);
    put(8'h8C, 1'b1, 1'b0);
    put(8'h80, 1'b1, 1'b0);
    put(8'hAA, 1'b0, 1'b1);
    // interrupted by ASCII, by an invalid lead, then cut short at the end
    put(8'hC3, 1'b1, 1'b0);
    put(8'h42, 1'b1, 1'b0);
    put(8'hE4, 1'b1, 1'b0);
    put(8'hB8, 1'b1, 1'b0);
    put(8'hF8, 1'b1, 1'b0);
    put(8'hF0, 1'b1, 1'b0);
    put(8'h9F, 1'b1, 1'b1);

    for (int s = 0; beat_q.size() < RAND_BEATS; s++) begin
      if (s == 3 || s == 30) make_string($urandom_range(110, 170));
      else make_string($urandom_range(0, 10));
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (beat_q.size() != 0 || in_valid || totals_q.size() != 0);
    repeat (DRAIN) @(posedge clk);

    if (failed) begin
      $display("== FAIL ==");
    end else begin
      $display("== PASS ==");
    end
    $finish;
  end

endmodule
